@@ src/ttf_pkg.sv @@
// ----------------------------------------------------------------------------
// ttf_pkg
// Shared types, widths and arithmetic helpers for the triangle tangent frame
// unit.
// ----------------------------------------------------------------------------
package ttf_pkg;

  localparam int PosW  = 32;  // Q15.16 position and texture coordinate
  localparam int NrmW  = 16;  // Q1.14 normal and result components
  localparam int DltW  = 33;  // exact delta
  localparam int MagW  = 32;  // delta magnitude
  localparam int PrdW  = 64;  // product magnitude
  localparam int TmW   = 63;  // face tangent magnitude
  localparam int SumW  = 62;  // sum of squares
  localparam int RootW = 31;  // square root
  localparam int NumW  = 45;  // division numerator
  localparam int QW    = 15;  // quotient
  localparam int CrsW  = 34;  // cross product term, Q5.28
  localparam int IdxW  = 5;
  localparam int SlotW = 2;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_DELTA,
    OP_MUL,
    OP_TDIFF,
    OP_MAX,
    OP_NORM,
    OP_SQ,
    OP_SQRT,
    OP_DIVI,
    OP_DIV,
    OP_CROSS,
    OP_FRAME
  } ttf_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MUL,
    ST_TDIFF,
    ST_MAX,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DIVI,
    ST_DIV,
    ST_CROSS,
    ST_FRAME,
    ST_WAIT
  } ttf_state_e;

  typedef struct packed {
    ttf_op_e          op;
    logic [IdxW-1:0]  idx;
    logic [SlotW-1:0] vtx;
    logic [SlotW-1:0] slot;
  } ttf_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic degen;
  } ttf_stat_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [PosW-1:0] tex_v;
    logic signed [NrmW-1:0] norm_x;
    logic signed [NrmW-1:0] norm_y;
    logic signed [NrmW-1:0] norm_z;
  } ttf_vertex_t;

  typedef struct packed {
    logic [SlotW-1:0]       vertex_slot;
    logic signed [NrmW-1:0] tangent_x;
    logic signed [NrmW-1:0] tangent_y;
    logic signed [NrmW-1:0] tangent_z;
    logic signed [NrmW-1:0] binormal_x;
    logic signed [NrmW-1:0] binormal_y;
    logic signed [NrmW-1:0] binormal_z;
    logic                   degenerate;
    logic                   last_of_face;
  } ttf_frame_t;

  function automatic logic [MagW-1:0] mag_of(input logic signed [DltW-1:0] d);
    logic signed [DltW-1:0] n;
    n = d[DltW-1] ? -d : d;
    return n[MagW-1:0];
  endfunction

  // Q5.28 to Q1.14, round half up, saturate
  function automatic logic signed [NrmW-1:0] rnd_sat(input logic signed [CrsW-1:0] x);
    logic signed [CrsW-1:0] y;
    logic signed [CrsW-1:0] q;
    logic signed [NrmW-1:0] r;
    y = x + CrsW'(8192);
    q = y >>> 14;
    if (q > CrsW'(32767)) begin
      r = 16'sh7fff;
    end else if (q < -CrsW'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = q[NrmW-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/ttf_if.sv @@
// ----------------------------------------------------------------------------
// ttf_if
// Valid/ready channels: vertex items in, tangent frame items out.
// ----------------------------------------------------------------------------
interface ttf_vtx_if;
  logic                           valid;
  logic                           ready;
  logic signed [ttf_pkg::PosW-1:0] pos_x;
  logic signed [ttf_pkg::PosW-1:0] pos_y;
  logic signed [ttf_pkg::PosW-1:0] pos_z;
  logic signed [ttf_pkg::PosW-1:0] tex_u;
  logic signed [ttf_pkg::PosW-1:0] tex_v;
  logic signed [ttf_pkg::NrmW-1:0] norm_x;
  logic signed [ttf_pkg::NrmW-1:0] norm_y;
  logic signed [ttf_pkg::NrmW-1:0] norm_z;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y,
                  norm_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y,
                norm_z, output ready);
endinterface

interface ttf_frm_if;
  logic                            valid;
  logic                            ready;
  logic [ttf_pkg::SlotW-1:0]       vertex_slot;
  logic signed [ttf_pkg::NrmW-1:0] tangent_x;
  logic signed [ttf_pkg::NrmW-1:0] tangent_y;
  logic signed [ttf_pkg::NrmW-1:0] tangent_z;
  logic signed [ttf_pkg::NrmW-1:0] binormal_x;
  logic signed [ttf_pkg::NrmW-1:0] binormal_y;
  logic signed [ttf_pkg::NrmW-1:0] binormal_z;
  logic                            degenerate;
  logic                            last_of_face;

  modport source (output valid, vertex_slot, tangent_x, tangent_y, tangent_z,
                  binormal_x, binormal_y, binormal_z, degenerate, last_of_face,
                  input ready);
  modport sink (input valid, vertex_slot, tangent_x, tangent_y, tangent_z,
                binormal_x, binormal_y, binormal_z, degenerate, last_of_face,
                output ready);
endinterface

@@ src/ttf_datapath.sv @@
// ----------------------------------------------------------------------------
// ttf_datapath
// Vertex store, shared multiplier, normalisation, square root, dividers and
// cross product unit, stepped by the controller.
// ----------------------------------------------------------------------------
module ttf_datapath (
  input  logic                clk_i,
  input  ttf_pkg::ttf_cmd_t    cmd_i,
  input  ttf_pkg::ttf_vertex_t vtx_i,
  output ttf_pkg::ttf_stat_t   stat_o,
  output ttf_pkg::ttf_frame_t  frame_o
);

  logic signed [ttf_pkg::PosW-1:0] pos_q  [3][3];
  logic signed [ttf_pkg::PosW-1:0] texv_q [3];
  logic signed [ttf_pkg::NrmW-1:0] nrm_q  [3][3];

  logic [ttf_pkg::MagW-1:0]  dmag_q  [6];
  logic                      dneg_q  [6];
  logic [ttf_pkg::MagW-1:0]  dvmag_q [2];
  logic                      dvneg_q [2];
  logic [ttf_pkg::PrdW-1:0]  pm_q    [6];
  logic                      ps_q    [6];
  logic [ttf_pkg::TmW-1:0]   tm_q    [3];
  logic                      tneg_q  [3];
  logic [ttf_pkg::TmW-1:0]   mx_q;
  logic                      degen_q;
  logic [ttf_pkg::SumW-1:0]  acc_q;
  logic [ttf_pkg::SumW-1:0]  res_q;
  logic [ttf_pkg::NumW-1:0]  rem_q   [3];
  logic [ttf_pkg::QW-1:0]    quo_q   [3];
  logic signed [ttf_pkg::CrsW-1:0] crs_q;
  logic signed [ttf_pkg::NrmW-1:0] bin_q [3];
  logic signed [ttf_pkg::NrmW-1:0] tan_q [3];
  ttf_pkg::ttf_frame_t       frame_q;

  logic [2:0]                      idx3;
  logic [ttf_pkg::PrdW-1:0]        prod;
  logic                            big;
  logic [ttf_pkg::PrdW-1:0]        pa [3];
  logic [ttf_pkg::PrdW-1:0]        pb [3];
  logic signed [ttf_pkg::PrdW-1:0] sa [3];
  logic signed [ttf_pkg::PrdW-1:0] sb [3];
  logic signed [ttf_pkg::PrdW-1:0] td [3];
  logic signed [ttf_pkg::PrdW-1:0] tabs [3];
  logic [ttf_pkg::TmW-1:0]         m01;
  logic [ttf_pkg::TmW-1:0]         mmax;
  logic [29:0]                     sq_op;
  logic [ttf_pkg::SumW-1:0]        sq;
  logic [ttf_pkg::SumW-1:0]        sbit;
  logic [ttf_pkg::SumW-1:0]        strial;
  logic [ttf_pkg::RootW-1:0]       root;
  logic [ttf_pkg::NumW-1:0]        dsh;
  logic signed [ttf_pkg::NrmW-1:0] uvec [3];
  logic signed [ttf_pkg::NrmW-1:0] nx, ny, nz;
  logic signed [ttf_pkg::NrmW-1:0] oa, ob, oc, od;
  logic [2:0]                      comp;

  function automatic logic signed [ttf_pkg::DltW-1:0] DltWx(
    input logic signed [ttf_pkg::PosW-1:0] v);
    return ttf_pkg::DltW'(v);
  endfunction

  assign idx3   = cmd_i.idx[2:0];
  assign prod   = {32'd0, dmag_q[idx3]} * {32'd0, dvmag_q[idx3[0] ? 1'b0 : 1'b1]};
  assign root   = res_q[ttf_pkg::RootW-1:0];
  assign dsh    = ttf_pkg::NumW'(root) << cmd_i.idx[3:0];
  assign sbit   = ttf_pkg::SumW'(1) << {cmd_i.idx, 1'b0};
  assign strial = res_q + sbit;
  assign sq_op  = tm_q[cmd_i.idx[1:0]][29:0];
  assign sq     = {32'd0, sq_op} * {32'd0, sq_op};
  assign comp   = cmd_i.idx[3:1];
  assign nx     = nrm_q[cmd_i.vtx][0];
  assign ny     = nrm_q[cmd_i.vtx][1];
  assign nz     = nrm_q[cmd_i.vtx][2];

  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 6; i++) begin
      big = big | (pm_q[i][63:62] != 2'b00);
    end
    for (int i = 0; i < 3; i++) begin
      pa[i]   = big ? (pm_q[2*i] >> 2) : pm_q[2*i];
      pb[i]   = big ? (pm_q[2*i+1] >> 2) : pm_q[2*i+1];
      sa[i]   = ps_q[2*i] ? -$signed(pa[i]) : $signed(pa[i]);
      sb[i]   = ps_q[2*i+1] ? -$signed(pb[i]) : $signed(pb[i]);
      td[i]   = sa[i] - sb[i];
      tabs[i] = td[i][63] ? -td[i] : td[i];
      uvec[i] = tneg_q[i] ? -$signed({1'b0, quo_q[i]}) : $signed({1'b0, quo_q[i]});
    end
    m01  = (tm_q[0] > tm_q[1]) ? tm_q[0] : tm_q[1];
    mmax = (tm_q[2] > m01) ? tm_q[2] : m01;
  end

  always_comb begin
    case (comp)
      3'd0: begin oa = ny;       ob = uvec[2]; oc = nz;       od = uvec[1]; end
      3'd1: begin oa = nz;       ob = uvec[0]; oc = nx;       od = uvec[2]; end
      3'd2: begin oa = nx;       ob = uvec[1]; oc = ny;       od = uvec[0]; end
      3'd3: begin oa = bin_q[1]; ob = nz;      oc = bin_q[2]; od = ny;      end
      3'd4: begin oa = bin_q[2]; ob = nx;      oc = bin_q[0]; od = nz;      end
      3'd5: begin oa = bin_q[0]; ob = ny;      oc = bin_q[1]; od = nx;      end
      default: begin oa = '0; ob = '0; oc = '0; od = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ttf_pkg::OP_LOAD: begin
        pos_q[cmd_i.slot][0] <= vtx_i.pos_x;
        pos_q[cmd_i.slot][1] <= vtx_i.pos_y;
        pos_q[cmd_i.slot][2] <= vtx_i.pos_z;
        texv_q[cmd_i.slot]   <= vtx_i.tex_v;
        nrm_q[cmd_i.slot][0] <= vtx_i.norm_x;
        nrm_q[cmd_i.slot][1] <= vtx_i.norm_y;
        nrm_q[cmd_i.slot][2] <= vtx_i.norm_z;
      end
      ttf_pkg::OP_DELTA: begin
        for (int i = 0; i < 3; i++) begin
          dmag_q[2*i]   <= ttf_pkg::mag_of(DltWx(pos_q[1][i]) - DltWx(pos_q[0][i]));
          dneg_q[2*i]   <= pos_q[1][i] < pos_q[0][i];
          dmag_q[2*i+1] <= ttf_pkg::mag_of(DltWx(pos_q[2][i]) - DltWx(pos_q[0][i]));
          dneg_q[2*i+1] <= pos_q[2][i] < pos_q[0][i];
        end
        dvmag_q[0] <= ttf_pkg::mag_of(DltWx(texv_q[1]) - DltWx(texv_q[0]));
        dvneg_q[0] <= texv_q[1] < texv_q[0];
        dvmag_q[1] <= ttf_pkg::mag_of(DltWx(texv_q[2]) - DltWx(texv_q[0]));
        dvneg_q[1] <= texv_q[2] < texv_q[0];
      end
      ttf_pkg::OP_MUL: begin
        pm_q[idx3] <= prod;
        ps_q[idx3] <= dneg_q[idx3] ^ dvneg_q[idx3[0] ? 1'b0 : 1'b1];
      end
      ttf_pkg::OP_TDIFF: begin
        for (int i = 0; i < 3; i++) begin
          tm_q[i]   <= tabs[i][ttf_pkg::TmW-1:0];
          tneg_q[i] <= td[i][63];
        end
      end
      ttf_pkg::OP_MAX: begin
        mx_q    <= mmax;
        degen_q <= (mmax == '0);
        acc_q   <= '0;
        res_q   <= '0;
      end
      ttf_pkg::OP_NORM: begin
        if (mx_q[62:34] != '0) begin
          mx_q <= mx_q >> 4;
          for (int i = 0; i < 3; i++) tm_q[i] <= tm_q[i] >> 4;
        end else if (mx_q[62:30] != '0) begin
          mx_q <= mx_q >> 1;
          for (int i = 0; i < 3; i++) tm_q[i] <= tm_q[i] >> 1;
        end else if (!mx_q[29] && mx_q[28:25] == 4'd0) begin
          mx_q <= mx_q << 4;
          for (int i = 0; i < 3; i++) tm_q[i] <= tm_q[i] << 4;
        end else if (!mx_q[29]) begin
          mx_q <= mx_q << 1;
          for (int i = 0; i < 3; i++) tm_q[i] <= tm_q[i] << 1;
        end
      end
      ttf_pkg::OP_SQ: begin
        acc_q <= acc_q + sq;
      end
      ttf_pkg::OP_SQRT: begin
        if (acc_q >= strial) begin
          acc_q <= acc_q - strial;
          res_q <= (res_q >> 1) + sbit;
        end else begin
          res_q <= res_q >> 1;
        end
      end
      ttf_pkg::OP_DIVI: begin
        for (int i = 0; i < 3; i++) begin
          rem_q[i] <= {1'b0, tm_q[i][29:0], 14'd0} + ttf_pkg::NumW'(root >> 1);
          quo_q[i] <= '0;
        end
      end
      ttf_pkg::OP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (rem_q[i] >= dsh) begin
            rem_q[i]                  <= rem_q[i] - dsh;
            quo_q[i][cmd_i.idx[3:0]] <= 1'b1;
          end
        end
      end
      ttf_pkg::OP_CROSS: begin
        if (!cmd_i.idx[0]) begin
          crs_q <= ttf_pkg::CrsW'(oa * ob) - ttf_pkg::CrsW'(oc * od);
        end else if (comp < 3'd3) begin
          bin_q[comp[1:0]] <= ttf_pkg::rnd_sat(crs_q);
        end else begin
          tan_q[2'(comp - 3'd3)] <= ttf_pkg::rnd_sat(crs_q);
        end
      end
      ttf_pkg::OP_FRAME: begin
        frame_q.vertex_slot  <= cmd_i.vtx;
        frame_q.tangent_x    <= degen_q ? '0 : tan_q[0];
        frame_q.tangent_y    <= degen_q ? '0 : tan_q[1];
        frame_q.tangent_z    <= degen_q ? '0 : tan_q[2];
        frame_q.binormal_x   <= degen_q ? '0 : bin_q[0];
        frame_q.binormal_y   <= degen_q ? '0 : bin_q[1];
        frame_q.binormal_z   <= degen_q ? '0 : bin_q[2];
        frame_q.degenerate   <= degen_q;
        frame_q.last_of_face <= (cmd_i.vtx == 2'd2);
      end
      default: begin
      end
    endcase
  end

  assign stat_o.norm_done = (mx_q[62:30] == '0) && mx_q[29];
  assign stat_o.degen     = degen_q;
  assign frame_o          = frame_q;

endmodule

@@ src/ttf_ctrl.sv @@
// ----------------------------------------------------------------------------
// ttf_ctrl
// Sequencer: counts held vertices, steps the datapath through the face
// tangent, its normalisation and the three per-vertex frames.
// ----------------------------------------------------------------------------
module ttf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ttf_pkg::ttf_stat_t stat_i,
  output ttf_pkg::ttf_cmd_t  cmd_o
);

  ttf_pkg::ttf_state_e            state_q, state_d;
  logic [ttf_pkg::IdxW-1:0]       idx_q, idx_d;
  logic [ttf_pkg::SlotW-1:0]      held_q, held_d;
  logic [ttf_pkg::SlotW-1:0]      vtx_q, vtx_d;
  logic                           ovalid_q, ovalid_d;
  logic                           third;

  assign third = held_q[1];

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    vtx_d   = vtx_q;
    case (state_q)
      ttf_pkg::ST_IDLE: begin
        if (in_valid_i && third) begin
          state_d = ttf_pkg::ST_DELTA;
        end
      end
      ttf_pkg::ST_DELTA: begin
        state_d = ttf_pkg::ST_MUL;
        idx_d   = '0;
      end
      ttf_pkg::ST_MUL: begin
        idx_d = idx_q + 5'd1;
        if (idx_q == 5'd5) begin
          state_d = ttf_pkg::ST_TDIFF;
        end
      end
      ttf_pkg::ST_TDIFF: state_d = ttf_pkg::ST_MAX;
      ttf_pkg::ST_MAX:   state_d = ttf_pkg::ST_NORM;
      ttf_pkg::ST_NORM: begin
        vtx_d = '0;
        if (stat_i.degen) begin
          state_d = ttf_pkg::ST_FRAME;
        end else if (stat_i.norm_done) begin
          state_d = ttf_pkg::ST_SQ;
          idx_d   = '0;
        end
      end
      ttf_pkg::ST_SQ: begin
        idx_d = idx_q + 5'd1;
        if (idx_q == 5'd2) begin
          state_d = ttf_pkg::ST_SQRT;
          idx_d   = 5'd30;
        end
      end
      ttf_pkg::ST_SQRT: begin
        idx_d = idx_q - 5'd1;
        if (idx_q == 5'd0) begin
          state_d = ttf_pkg::ST_DIVI;
        end
      end
      ttf_pkg::ST_DIVI: begin
        state_d = ttf_pkg::ST_DIV;
        idx_d   = 5'd14;
      end
      ttf_pkg::ST_DIV: begin
        idx_d = idx_q - 5'd1;
        if (idx_q == 5'd0) begin
          state_d = ttf_pkg::ST_CROSS;
          idx_d   = '0;
        end
      end
      ttf_pkg::ST_CROSS: begin
        idx_d = idx_q + 5'd1;
        if (idx_q == 5'd11) begin
          state_d = ttf_pkg::ST_FRAME;
        end
      end
      ttf_pkg::ST_FRAME: state_d = ttf_pkg::ST_WAIT;
      ttf_pkg::ST_WAIT: begin
        if (out_ready_i) begin
          idx_d = '0;
          vtx_d = vtx_q + 2'd1;
          if (vtx_q == 2'd2) begin
            state_d = ttf_pkg::ST_IDLE;
          end else if (stat_i.degen) begin
            state_d = ttf_pkg::ST_FRAME;
          end else begin
            state_d = ttf_pkg::ST_CROSS;
          end
        end
      end
      default: state_d = ttf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = ttf_pkg::OP_IDLE;
    cmd_o.idx  = idx_q;
    cmd_o.vtx  = vtx_q;
    cmd_o.slot = third ? 2'd2 : held_q;
    case (state_q)
      ttf_pkg::ST_IDLE:  cmd_o.op = in_valid_i ? ttf_pkg::OP_LOAD : ttf_pkg::OP_IDLE;
      ttf_pkg::ST_DELTA: cmd_o.op = ttf_pkg::OP_DELTA;
      ttf_pkg::ST_MUL:   cmd_o.op = ttf_pkg::OP_MUL;
      ttf_pkg::ST_TDIFF: cmd_o.op = ttf_pkg::OP_TDIFF;
      ttf_pkg::ST_MAX:   cmd_o.op = ttf_pkg::OP_MAX;
      ttf_pkg::ST_NORM:  cmd_o.op = ttf_pkg::OP_NORM;
      ttf_pkg::ST_SQ:    cmd_o.op = ttf_pkg::OP_SQ;
      ttf_pkg::ST_SQRT:  cmd_o.op = ttf_pkg::OP_SQRT;
      ttf_pkg::ST_DIVI:  cmd_o.op = ttf_pkg::OP_DIVI;
      ttf_pkg::ST_DIV:   cmd_o.op = ttf_pkg::OP_DIV;
      ttf_pkg::ST_CROSS: cmd_o.op = ttf_pkg::OP_CROSS;
      ttf_pkg::ST_FRAME: cmd_o.op = ttf_pkg::OP_FRAME;
      default:           cmd_o.op = ttf_pkg::OP_IDLE;
    endcase
  end

  always_comb begin
    held_d = held_q;
    if (state_q == ttf_pkg::ST_IDLE && in_valid_i) begin
      held_d = third ? 2'd0 : held_q + 2'd1;
    end
    ovalid_d = (state_q == ttf_pkg::ST_FRAME) || (ovalid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ttf_pkg::ST_IDLE;
      idx_q    <= '0;
      held_q   <= '0;
      vtx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      held_q   <= held_d;
      vtx_q    <= vtx_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == ttf_pkg::ST_IDLE);
  assign out_valid_o = ovalid_q;

`ifndef SYNTHESIS
  a_valid_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> state_q == ttf_pkg::ST_WAIT)
    else $error("result valid outside wait state");
  a_third_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && third) |=> state_q == ttf_pkg::ST_DELTA && held_q == 2'd0)
    else $error("third vertex did not start face");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |=> ovalid_q && $stable(vtx_q))
    else $error("stalled result lost");
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != 2'd3)
    else $error("vertex count out of range");
`endif

endmodule

@@ src/triangle_tangent_frame_unit.sv @@
// ----------------------------------------------------------------------------
// triangle_tangent_frame_unit
// Per-triangle tangent space basis in fixed point.
// ----------------------------------------------------------------------------
// Vertices are taken one at a time; the first two of a triangle are held. The
// third starts the face: deltas, six products on one 32x32 multiplier,
// tangent forming and its maximum, normalising shifts of up to four bits a
// cycle, squares, a bit-serial square root and three parallel 15-step
// dividers. Each of the three frames is then worked out on the cross product
// unit and loaded into the output register, and the block holds off the next
// vertex until the third frame is taken. A degenerate face skips the squares,
// square root, division and cross products. No input is taken while a
// triangle's frames are being worked out or delivered.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  ttf_vtx_if.sink       vtx_i,
  ttf_frm_if.source     frm_o
);

  ttf_pkg::ttf_cmd_t    cmd;
  ttf_pkg::ttf_stat_t   stat;
  ttf_pkg::ttf_vertex_t vtx;
  ttf_pkg::ttf_frame_t  frame;

  assign vtx.pos_x  = vtx_i.pos_x;
  assign vtx.pos_y  = vtx_i.pos_y;
  assign vtx.pos_z  = vtx_i.pos_z;
  assign vtx.tex_v  = vtx_i.tex_v;
  assign vtx.norm_x = vtx_i.norm_x;
  assign vtx.norm_y = vtx_i.norm_y;
  assign vtx.norm_z = vtx_i.norm_z;

  ttf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vtx_i.valid),
    .in_ready_o  (vtx_i.ready),
    .out_valid_o (frm_o.valid),
    .out_ready_i (frm_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ttf_datapath u_datapath (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .vtx_i   (vtx),
    .stat_o  (stat),
    .frame_o (frame)
  );

  assign frm_o.vertex_slot  = frame.vertex_slot;
  assign frm_o.tangent_x    = frame.tangent_x;
  assign frm_o.tangent_y    = frame.tangent_y;
  assign frm_o.tangent_z    = frame.tangent_z;
  assign frm_o.binormal_x   = frame.binormal_x;
  assign frm_o.binormal_y   = frame.binormal_y;
  assign frm_o.binormal_z   = frame.binormal_z;
  assign frm_o.degenerate   = frame.degenerate;
  assign frm_o.last_of_face = frame.last_of_face;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the triangle tangent frame unit: vertex items are sent through the
// input channel, a predictor works out the three frames of each triangle and
// every frame item on the output channel is compared against them in order.
// ----------------------------------------------------------------------------
module tb_top;

  logic clk_i;
  logic rst_ni;
  int   n_err;
  bit   no_idle;

  ttf_vtx_if vtx ();
  ttf_frm_if frm ();

  triangle_tangent_frame_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx.sink),
    .frm_o  (frm.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  // predictor state: first two vertices of the current triangle
  ttf_pkg::ttf_vertex_t held_vtx [2];
  int                   n_held;
  ttf_pkg::ttf_frame_t  frames_due [$];

  function automatic logic signed [ttf_pkg::NrmW-1:0] q14_round(input longint x);
    longint y;
    longint q;
    y = x + 8192;
    q = y >>> 14;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[ttf_pkg::NrmW-1:0];
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs64(input longint a);
    return a < 0 ? 64'd0 - a : a;
  endfunction

  task automatic predict_frames(input ttf_pkg::ttf_vertex_t v2);
    ttf_pkg::ttf_vertex_t vv [3];
    longint               dv1, dv2, d1, d2, a, b, t;
    longint unsigned      pm [6];
    bit                   ps [6];
    longint unsigned      tm [3];
    bit                   tneg [3];
    longint unsigned      mx, s, r;
    longint               u [3];
    longint               nx, ny, nz, bx, by, bz;
    bit                   big, degen;
    int                   sh;
    ttf_pkg::ttf_frame_t  f;
    vv[0] = held_vtx[0];
    vv[1] = held_vtx[1];
    vv[2] = v2;
    dv1 = longint'(vv[1].tex_v) - longint'(vv[0].tex_v);
    dv2 = longint'(vv[2].tex_v) - longint'(vv[0].tex_v);
    for (int i = 0; i < 3; i++) begin
      case (i)
        0: begin
          d1 = longint'(vv[1].pos_x) - longint'(vv[0].pos_x);
          d2 = longint'(vv[2].pos_x) - longint'(vv[0].pos_x);
        end
        1: begin
          d1 = longint'(vv[1].pos_y) - longint'(vv[0].pos_y);
          d2 = longint'(vv[2].pos_y) - longint'(vv[0].pos_y);
        end
        default: begin
          d1 = longint'(vv[1].pos_z) - longint'(vv[0].pos_z);
          d2 = longint'(vv[2].pos_z) - longint'(vv[0].pos_z);
        end
      endcase
      pm[2*i] = abs64(d1) * abs64(dv2);
      ps[2*i] = (d1 < 0) != (dv2 < 0);
      pm[2*i+1] = abs64(d2) * abs64(dv1);
      ps[2*i+1] = (d2 < 0) != (dv1 < 0);
    end
    big = 0;
    for (int i = 0; i < 6; i++) if (pm[i] >= (64'd1 << 62)) big = 1;
    sh = big ? 2 : 0;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      a = longint'(pm[2*i] >> sh);
      b = longint'(pm[2*i+1] >> sh);
      if (ps[2*i]) a = -a;
      if (ps[2*i+1]) b = -b;
      t = a - b;
      tneg[i] = t < 0;
      tm[i] = abs64(t);
      if (tm[i] > mx) mx = tm[i];
    end
    degen = (mx == 0);
    u[0] = 0; u[1] = 0; u[2] = 0;
    if (!degen) begin
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) tm[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) tm[i] <<= 1;
      end
      s = tm[0] * tm[0] + tm[1] * tm[1] + tm[2] * tm[2];
      r = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
        a = longint'(((tm[i] << 14) + (r >> 1)) / r);
        u[i] = tneg[i] ? -a : a;
      end
    end
    for (int k = 0; k < 3; k++) begin
      f = '0;
      f.vertex_slot = k[ttf_pkg::SlotW-1:0];
      f.degenerate = degen;
      f.last_of_face = (k == 2);
      if (!degen) begin
        nx = longint'(vv[k].norm_x);
        ny = longint'(vv[k].norm_y);
        nz = longint'(vv[k].norm_z);
        bx = longint'(q14_round(ny * u[2] - nz * u[1]));
        by = longint'(q14_round(nz * u[0] - nx * u[2]));
        bz = longint'(q14_round(nx * u[1] - ny * u[0]));
        f.binormal_x = bx[ttf_pkg::NrmW-1:0];
        f.binormal_y = by[ttf_pkg::NrmW-1:0];
        f.binormal_z = bz[ttf_pkg::NrmW-1:0];
        f.tangent_x = q14_round(by * nz - bz * ny);
        f.tangent_y = q14_round(bz * nx - bx * nz);
        f.tangent_z = q14_round(bx * ny - by * nx);
      end
      frames_due = {frames_due, f};
    end
  endtask

  task automatic send_vertex(input ttf_pkg::ttf_vertex_t v,
                             input logic signed [ttf_pkg::PosW-1:0] u);
    if (!no_idle) begin
      while ($urandom_range(99) < 15) begin
        vtx.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    vtx.valid  <= 1'b1;
    vtx.pos_x  <= v.pos_x;
    vtx.pos_y  <= v.pos_y;
    vtx.pos_z  <= v.pos_z;
    vtx.tex_u  <= u;
    vtx.tex_v  <= v.tex_v;
    vtx.norm_x <= v.norm_x;
    vtx.norm_y <= v.norm_y;
    vtx.norm_z <= v.norm_z;
    @(posedge clk_i);
    while (!vtx.ready) @(posedge clk_i);
    if (n_held == 2) begin
      predict_frames(v);
      n_held = 0;
    end else begin
      held_vtx[n_held] = v;
      n_held++;
    end
  endtask

  function automatic ttf_pkg::ttf_vertex_t rand_vertex(input int pscale);
    ttf_pkg::ttf_vertex_t v;
    v.pos_x = $signed($urandom) >>> pscale;
    v.pos_y = $signed($urandom) >>> pscale;
    v.pos_z = $signed($urandom) >>> pscale;
    v.tex_v = $signed($urandom) >>> pscale;
    v.norm_x = ttf_pkg::NrmW'($urandom);
    v.norm_y = ttf_pkg::NrmW'($urandom);
    v.norm_z = ttf_pkg::NrmW'($urandom);
    return v;
  endfunction

  function automatic ttf_pkg::ttf_vertex_t unit_normal(input ttf_pkg::ttf_vertex_t v,
                                                       input int axis);
    v.norm_x = 0; v.norm_y = 0; v.norm_z = 0;
    case (axis)
      0: v.norm_x = 16'sd16384;
      1: v.norm_y = 16'sd16384;
      default: v.norm_z = -16'sd16384;
    endcase
    return v;
  endfunction

  // output side: random stall, compare against the oldest due frame
  initial begin
    ttf_pkg::ttf_frame_t e;
    frm.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (frm.valid && frm.ready) begin
        if (frames_due.size() == 0) begin
          $error("frame item with none expected");
          n_err++;
        end else begin
          e = frames_due.pop_front();
          if (frm.vertex_slot !== e.vertex_slot) begin
            $error("vertex_slot exp %0d got %0d", e.vertex_slot, frm.vertex_slot); n_err++;
          end
          if (frm.tangent_x !== e.tangent_x) begin
            $error("tangent_x exp %0d got %0d", e.tangent_x, frm.tangent_x); n_err++;
          end
          if (frm.tangent_y !== e.tangent_y) begin
            $error("tangent_y exp %0d got %0d", e.tangent_y, frm.tangent_y); n_err++;
          end
          if (frm.tangent_z !== e.tangent_z) begin
            $error("tangent_z exp %0d got %0d", e.tangent_z, frm.tangent_z); n_err++;
          end
          if (frm.binormal_x !== e.binormal_x) begin
            $error("binormal_x exp %0d got %0d", e.binormal_x, frm.binormal_x); n_err++;
          end
          if (frm.binormal_y !== e.binormal_y) begin
            $error("binormal_y exp %0d got %0d", e.binormal_y, frm.binormal_y); n_err++;
          end
          if (frm.binormal_z !== e.binormal_z) begin
            $error("binormal_z exp %0d got %0d", e.binormal_z, frm.binormal_z); n_err++;
          end
          if (frm.degenerate !== e.degenerate) begin
            $error("degenerate exp %0d got %0d", e.degenerate, frm.degenerate); n_err++;
          end
          if (frm.last_of_face !== e.last_of_face) begin
            $error("last_of_face exp %0d got %0d", e.last_of_face, frm.last_of_face);
            n_err++;
          end
        end
      end
      frm.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 15);
    end
  end

  task automatic test_extremes();
    ttf_pkg::ttf_vertex_t v;
    // full-scale positions and v coordinates force the large product path
    v.pos_x = 32'sh7fffffff; v.pos_y = 32'sh80000000; v.pos_z = 0;
    v.tex_v = 32'sh80000000;
    v.norm_x = 16'sh7fff; v.norm_y = 16'sh8000; v.norm_z = 0;
    send_vertex(v, 32'sh7fffffff);
    v.pos_x = 32'sh80000000; v.pos_y = 32'sh7fffffff; v.pos_z = 32'sh7fffffff;
    v.tex_v = 32'sh7fffffff;
    v.norm_x = 16'sh8000; v.norm_y = 16'sh8000; v.norm_z = 16'sh8000;
    send_vertex(v, 32'sh80000000);
    v.pos_x = 32'sh7fffffff; v.pos_y = 32'sh80000000; v.pos_z = 32'sh80000000;
    v.tex_v = 32'sh80000000;
    v.norm_x = 16'sh7fff; v.norm_y = 16'sh7fff; v.norm_z = 16'sh7fff;
    send_vertex(v, 0);
    // tiny deltas exercise the left normalising shift
    for (int k = 0; k < 3; k++) begin
      v = '0;
      v.pos_x = k; v.tex_v = (k == 1) ? 0 : -1;
      v.norm_x = -1; v.norm_y = 16'sd16384; v.norm_z = 1;
      send_vertex(v, -1);
    end
  endtask

  task automatic test_degenerate();
    ttf_pkg::ttf_vertex_t v;
    // equal v coordinates, then coincident positions
    for (int k = 0; k < 3; k++) begin
      v = rand_vertex(4);
      v.tex_v = 32'sh00010000;
      send_vertex(v, $urandom);
    end
    v = rand_vertex(0);
    for (int k = 0; k < 3; k++) begin
      v.tex_v = $urandom;
      send_vertex(v, $urandom);
    end
  endtask

  task automatic test_axis_frames();
    ttf_pkg::ttf_vertex_t v;
    // clean planar triangles with unit normals
    for (int t = 0; t < 3; t++) begin
      for (int k = 0; k < 3; k++) begin
        v = '0;
        v.pos_x = (k == 1) ? 32'sh00010000 : 0;
        v.pos_y = (k == 2) ? 32'sh00010000 : 0;
        v.tex_v = (k == 2) ? 32'sh00010000 : 0;
        send_vertex(unit_normal(v, t), (k == 1) ? 32'sh00010000 : 0);
      end
    end
  endtask

  task automatic test_random(input int n_vtx);
    ttf_pkg::ttf_vertex_t v;
    int                   sc;
    for (int i = 0; i < n_vtx; i++) begin
      no_idle = (i >= n_vtx / 3) && (i < n_vtx / 2);
      if (n_held == 0) sc = $urandom_range(24);
      v = rand_vertex(sc);
      if ($urandom_range(9) == 0) v.tex_v = held_vtx[0].tex_v;
      if ($urandom_range(3) == 0) v = unit_normal(v, $urandom_range(2));
      send_vertex(v, $urandom);
    end
    no_idle = 0;
  endtask

  initial begin
    int guard;
    n_err = 0;
    n_held = 0;
    no_idle = 0;
    vtx.valid = 1'b0;
    vtx.pos_x = '0; vtx.pos_y = '0; vtx.pos_z = '0;
    vtx.tex_u = '0; vtx.tex_v = '0;
    vtx.norm_x = '0; vtx.norm_y = '0; vtx.norm_z = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_degenerate();
    test_axis_frames();
    test_random(210);
    vtx.valid <= 1'b0;
    guard = 0;
    while (frames_due.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
    if (n_err == 0 && frames_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ttf_pkg.sv
src/ttf_if.sv
src/ttf_datapath.sv
src/ttf_ctrl.sv
src/triangle_tangent_frame_unit.sv
tb/tb_top.sv
